// ===== hdl/rlc_pkg.sv =====
package rlc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int OUT_BITS = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       token_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] acc_value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_BIN = 2'd1,
    MODE_OCT = 2'd2,
    MODE_HEX = 2'd3
  } base_mode_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DIVZ   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_OR    = 8'h7C;
  localparam logic [7:0] CH_XOR   = 8'h5E;
  localparam logic [7:0] CH_SHL   = 8'h3C;
  localparam logic [7:0] CH_SHR   = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_X     = 8'h78;

  // Digit value of a character, 16 when it is no digit of the radix.
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [4:0] radix);
    logic [4:0] d;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'd55);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h57);
    return (d < radix) ? d : 5'd16;
  endfunction

  // One queued job for the back end: a finished operand and its operator.
  typedef struct packed {
    logic [7:0]  op;
    logic        load;
    logic [63:0] value;
  } job_t;

endpackage

// ===== hdl/rlc_front.sv =====
module rlc_front #(
  parameter int WORD_BITS = rlc_pkg::WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rlc_pkg::in_item_t in_data,
  input  logic              in_valid,
  output logic              in_ready,
  output rlc_pkg::job_t     job,
  output logic              job_valid,
  input  logic              job_ready
);

  localparam logic [WORD_BITS-1:0] ZERO_W = '0;

  logic [1:0]           phase;
  logic [7:0]           pending_operator;
  logic [7:0]           first_char;
  logic [1:0]           char_position;
  rlc_pkg::base_mode_t  base_mode;
  logic                 negative_sign;
  logic                 decimal_stopped;
  logic [WORD_BITS-1:0] operand_value;

  // A finished operand waits in the job register until the back end takes it.
  assign in_ready = !job_valid;

  function automatic logic [4:0] radix_of(input rlc_pkg::base_mode_t m);
    case (m)
      rlc_pkg::MODE_BIN: return 5'd2;
      rlc_pkg::MODE_OCT: return 5'd8;
      rlc_pkg::MODE_HEX: return 5'd16;
      default:           return 5'd10;
    endcase
  endfunction

  // Operators that the back end carries out; any other one ends the session.
  function automatic logic op_known(input logic [7:0] op);
    return op inside {rlc_pkg::CH_PLUS, rlc_pkg::CH_MINUS, rlc_pkg::CH_MUL,
                      rlc_pkg::CH_DIV, rlc_pkg::CH_AND, rlc_pkg::CH_OR,
                      rlc_pkg::CH_XOR, rlc_pkg::CH_SHL, rlc_pkg::CH_SHR};
  endfunction

  typedef struct packed {
    logic [WORD_BITS-1:0] v;
    logic                 neg;
    logic                 stop;
  } acc_t;

  function automatic acc_t take(input acc_t a, input rlc_pkg::base_mode_t m,
                                input logic [7:0] c, input logic first);
    acc_t r;
    logic [4:0] d;
    logic [4:0] rx;
    r = a;
    rx = radix_of(m);
    d = rlc_pkg::digit_of(c, rx);
    if (m == rlc_pkg::MODE_DEC) begin
      if (first && (c == rlc_pkg::CH_MINUS || c == rlc_pkg::CH_PLUS)) begin
        r.neg = (c == rlc_pkg::CH_MINUS);
      end else if (!a.stop) begin
        if (d == 5'd16) r.stop = 1'b1;
        else r.v = WORD_BITS'(a.v * rx + WORD_BITS'(d));
      end
    end else if (d != 5'd16) begin
      r.v = WORD_BITS'(a.v * rx + WORD_BITS'(d));
    end
    return r;
  endfunction

  acc_t cur, a0, a1;
  rlc_pkg::base_mode_t mode2;
  logic [7:0] c;

  always_comb begin
    c = in_data.char_code;
    cur = '{v: operand_value, neg: negative_sign, stop: decimal_stopped};
    if (c == rlc_pkg::CH_B) mode2 = rlc_pkg::MODE_BIN;
    else if (c == rlc_pkg::CH_X) mode2 = rlc_pkg::MODE_HEX;
    else if (first_char == rlc_pkg::CH_ZERO) mode2 = rlc_pkg::MODE_OCT;
    else mode2 = rlc_pkg::MODE_DEC;
    a0 = take('{v: ZERO_W, neg: 1'b0, stop: 1'b0}, mode2, first_char, 1'b1);
    a1 = take(a0, mode2, c, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      pending_operator <= '0;
      first_char <= '0;
      char_position <= '0;
      base_mode <= rlc_pkg::MODE_DEC;
      negative_sign <= 1'b0;
      decimal_stopped <= 1'b0;
      operand_value <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        if (phase == 2'd1) begin
          if (char_position == 2'd0) pending_operator <= c;
          char_position <= in_data.token_end ? 2'd0 : 2'd1;
          if (in_data.token_end) phase <= 2'd2;
        end else begin
          acc_t nx;
          logic fin;
          fin = in_data.token_end;
          nx = cur;
          if (char_position == 2'd0) begin
            first_char <= c;
            if (fin) begin
              if (c == rlc_pkg::CH_ZERO) begin
                nx = '{v: ZERO_W, neg: 1'b0, stop: 1'b0};
              end else begin
                nx = take('{v: ZERO_W, neg: 1'b0, stop: 1'b0}, rlc_pkg::MODE_DEC, c,
                          1'b1);
              end
            end
          end else if (char_position == 2'd1) begin
            base_mode <= mode2;
            nx = a1;
          end else begin
            nx = take(cur, base_mode, c, 1'b0);
          end
          operand_value <= nx.v;
          negative_sign <= nx.neg;
          decimal_stopped <= nx.stop;
          if (fin) char_position <= 2'd0;
          else if (char_position == 2'd0) char_position <= 2'd1;
          else char_position <= 2'd2;
          if (fin) begin
            job_valid <= 1'b1;
            job.op <= pending_operator;
            job.load <= (phase != 2'd2);
            job.value <= 64'(nx.neg ? WORD_BITS'(ZERO_W - nx.v) : nx.v);
            // An unknown operator ends the session, so a first operand follows.
            phase <= (phase == 2'd2 && !op_known(pending_operator)) ? 2'd0 : 2'd1;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/rlc_back.sv =====
module rlc_back #(
  parameter int WORD_BITS = rlc_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  rlc_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_ready,
  output rlc_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int CW = $clog2(WORD_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] acc, res, mq, rem, dv;
  logic                 neg_q;
  logic [1:0]           st;
  logic [CW-1:0]        cnt;
  logic                 unk;

  logic [WORD_BITS-1:0] yv, ma, mb;
  logic [WORD_BITS:0]   trial;

  logic [WORD_BITS-1:0] alu_res, alu_mq;
  logic [1:0]           alu_st;
  state_t               alu_state;

  assign job_ready = (state == S_IDLE) && !out_valid;
  assign yv = job.value[WORD_BITS-1:0];
  assign ma = acc[WORD_BITS-1] ? -acc : acc;
  assign mb = yv[WORD_BITS-1] ? -yv : yv;
  assign trial = {rem, mq[WORD_BITS-1]} - {1'b0, dv};

  // Every operation but multiply and a divide by non-zero finishes here; those only set up their loops.
  always_comb begin
    alu_res = acc;
    alu_st = rlc_pkg::ST_OK;
    alu_state = S_DONE;
    alu_mq = yv;
    case (job.op)
      rlc_pkg::CH_PLUS:  alu_res = acc + yv;
      rlc_pkg::CH_MINUS: alu_res = acc - yv;
      rlc_pkg::CH_AND:   alu_res = acc & yv;
      rlc_pkg::CH_OR:    alu_res = acc | yv;
      rlc_pkg::CH_XOR:   alu_res = acc ^ yv;
      rlc_pkg::CH_SHL:   alu_res = (yv >= WORD_BITS'(WORD_BITS)) ? '0 : acc << yv;
      rlc_pkg::CH_SHR:   alu_res = (yv >= WORD_BITS'(WORD_BITS)) ?
                                   {WORD_BITS{acc[WORD_BITS-1]}} :
                                   WORD_BITS'($signed(acc) >>> yv);
      rlc_pkg::CH_MUL: begin
        alu_res = '0;
        alu_state = S_MUL;
      end
      rlc_pkg::CH_DIV: begin
        if (yv == '0) alu_st = rlc_pkg::ST_DIVZ;
        else begin
          alu_mq = ma;
          alu_state = S_DIV;
        end
      end
      default: alu_st = rlc_pkg::ST_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc <= '0;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (job_valid && job_ready) begin
          if (job.load) begin
            acc <= yv;
          end else begin
            st <= alu_st;
            unk <= (alu_st == rlc_pkg::ST_UNKNOWN);
            res <= alu_res;
            mq <= alu_mq;
            dv <= mb;
            rem <= '0;
            cnt <= '0;
            neg_q <= acc[WORD_BITS-1] ^ yv[WORD_BITS-1];
            state <= alu_state;
          end
        end
        S_MUL: begin
          // Shift-add, one multiplier bit per cycle.
          res <= (res << 1) + (mq[WORD_BITS-1] ? acc : '0);
          mq <= mq << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(WORD_BITS - 1)) state <= S_DONE;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (!trial[WORD_BITS]) begin
            rem <= trial[WORD_BITS-1:0];
            mq <= {mq[WORD_BITS-2:0], 1'b1};
          end else begin
            rem <= {rem[WORD_BITS-2:0], mq[WORD_BITS-1]};
            mq <= {mq[WORD_BITS-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(WORD_BITS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_data.status <= st;
          out_data.acc_value <= 32'($signed(res));
          acc <= unk ? '0 : res;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DIV && cnt == CW'(WORD_BITS - 1)) begin
        res <= neg_q ? -({mq[WORD_BITS-2:0], ~trial[WORD_BITS]}) :
                       {mq[WORD_BITS-2:0], ~trial[WORD_BITS]};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) job_ready |-> !out_valid)
    else $error("job taken while result pending");
  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while waiting");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_MUL || state == S_DONE))
    else $error("multiply left early");

endmodule

// ===== hdl/radix_literal_calculator.sv =====
// Path: a second operand's last beat is registered in the front end's job register, taken
// by the back end into its result register, looped bit-serially through S_MUL or S_DIV for
// multiply and divide, and registered as the result in S_DONE.
// Throughput: one character beat per cycle while in_ready is high; after an operand's last
// beat in_ready stays low until the back end, once idle with no result held, takes the job.
// Reset (rst, synchronous) clears the session.
module radix_literal_calculator #(
  parameter int WORD_BITS = rlc_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  rlc_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output rlc_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);

  rlc_pkg::job_t job;
  logic job_valid, job_ready;

  // The front end parses literals; its job register is the queue to the back.
  rlc_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk, .rst, .in_data, .in_valid, .in_ready,
    .job, .job_valid, .job_ready
  );

  rlc_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk, .rst, .job, .job_valid, .job_ready,
    .out_data, .out_valid, .out_ready
  );

endmodule
